// ----- hdl/jsu_pkg.sv -----
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int DATA_MAX = 3;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_B = 8'h62;
    localparam logic [7:0] CHAR_F = 8'h66;
    localparam logic [7:0] CHAR_N = 8'h6e;
    localparam logic [7:0] CHAR_R = 8'h72;
    localparam logic [7:0] CHAR_T = 8'h74;
    localparam logic [7:0] CHAR_U = 8'h75;
    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0c;
    localparam logic [7:0] CTRL_LF = 8'h0a;
    localparam logic [7:0] CTRL_CR = 8'h0d;
    localparam logic [7:0] CTRL_TAB = 8'h09;

    localparam logic [7:0] UTF8_CONT = 8'h80;
    localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
    localparam logic [7:0] UTF8_LEAD3 = 8'he0;

    typedef enum logic [2:0] {
        PHASE_IDLE = 3'd0,
        PHASE_STR  = 3'd1,
        PHASE_ESC  = 3'd2,
        PHASE_HEX  = 3'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_t;

    typedef struct packed {
        logic [7:0] data_byte;
        kind_t      kind;
        logic       last;
    } result_t;

    // work for one input beat: up to three data bytes, then an optional close or error
    typedef struct packed {
        logic [DATA_MAX-1:0][7:0] data;
        logic [1:0]               ndata;
        logic                     has_tail;
        kind_t                    tail_kind;
    } cmd_t;

endpackage

// ----- hdl/json_string_unescape_utf8.sv -----
// a text beat's results go through the command queue, then the output register
// throughput: one text beat per cycle while the queue is not full; results leave
//   at one per cycle while result_stall is low, as the queue absorbs input
// text input stalls only while the command queue is full
// reset: asynchronous active low; decoder returns to idle, queue and output empty
module json_string_unescape_utf8
#(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_stall,
    input  jsu_pkg::text_t   text,
    output logic             result_valid,
    input  logic             result_stall,
    output jsu_pkg::result_t result
);

    logic          push;
    logic          pop;
    logic          full;
    logic          head_valid;
    jsu_pkg::cmd_t push_cmd;
    jsu_pkg::cmd_t head_cmd;

    jsu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text       (text),
        .full       (full),
        .text_stall (text_stall),
        .push       (push),
        .cmd        (push_cmd)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    jsu_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .result_stall (result_stall),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- hdl/jsu_front.sv -----
module jsu_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           text_valid,
    input  jsu_pkg::text_t text,
    input  logic           full,
    output logic           text_stall,
    output logic           push,
    output jsu_pkg::cmd_t  cmd
);

    jsu_pkg::phase_t phase_reg;
    jsu_pkg::phase_t phase_next;
    logic [1:0]      hex_count_reg;
    logic [1:0]      hex_count_next;
    logic [15:0]     code_point_reg;
    logic [15:0]     code_point_next;
    logic [15:0]     cp_new;
    logic            idle_err;
    logic            accept;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]})
            v = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            v = 4'(c[3:0] + 4'd9);
        return v;
    endfunction

    assign text_stall = full;
    assign accept = text_valid && !full;
    assign cp_new = {code_point_reg[11:0], hex_value(text.text_byte)};

    always_comb
    begin
        phase_next = phase_reg;
        hex_count_next = hex_count_reg;
        code_point_next = code_point_reg;
        cmd = '0;
        cmd.tail_kind = jsu_pkg::KIND_DATA;
        idle_err = 1'b0;
        case (phase_reg)
            jsu_pkg::PHASE_STR:
            begin
                if (text.text_byte == jsu_pkg::CHAR_QUOTE
                    || text.text_byte == jsu_pkg::CHAR_NUL)
                begin
                    cmd.has_tail = 1'b1;
                    cmd.tail_kind = jsu_pkg::KIND_CLOSE;
                    phase_next = jsu_pkg::PHASE_IDLE;
                end
                else if (text.text_byte == jsu_pkg::CHAR_BACKSLASH)
                begin
                    phase_next = jsu_pkg::PHASE_ESC;
                end
                else
                begin
                    cmd.data[0] = text.text_byte;
                    cmd.ndata = 2'd1;
                end
            end
            jsu_pkg::PHASE_ESC:
            begin
                phase_next = jsu_pkg::PHASE_STR;
                case (text.text_byte)
                    jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH:
                    begin
                        cmd.data[0] = text.text_byte;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_B:
                    begin
                        cmd.data[0] = jsu_pkg::CTRL_BS;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_F:
                    begin
                        cmd.data[0] = jsu_pkg::CTRL_FF;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_N:
                    begin
                        cmd.data[0] = jsu_pkg::CTRL_LF;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_R:
                    begin
                        cmd.data[0] = jsu_pkg::CTRL_CR;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_T:
                    begin
                        cmd.data[0] = jsu_pkg::CTRL_TAB;
                        cmd.ndata = 2'd1;
                    end
                    jsu_pkg::CHAR_U:
                    begin
                        phase_next = jsu_pkg::PHASE_HEX;
                        hex_count_next = 2'd0;
                        code_point_next = 16'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            jsu_pkg::PHASE_HEX:
            begin
                if (hex_count_reg == 2'd3)
                begin
                    if (cp_new[15:7] == 9'd0)
                    begin
                        cmd.data[0] = cp_new[7:0];
                        cmd.ndata = 2'd1;
                    end
                    else if (cp_new[15:11] == 5'd0)
                    begin
                        cmd.data[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp_new[10:6]};
                        cmd.data[1] = jsu_pkg::UTF8_CONT | {2'd0, cp_new[5:0]};
                        cmd.ndata = 2'd2;
                    end
                    else
                    begin
                        cmd.data[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp_new[15:12]};
                        cmd.data[1] = jsu_pkg::UTF8_CONT | {2'd0, cp_new[11:6]};
                        cmd.data[2] = jsu_pkg::UTF8_CONT | {2'd0, cp_new[5:0]};
                        cmd.ndata = 2'd3;
                    end
                    hex_count_next = 2'd0;
                    code_point_next = 16'd0;
                    phase_next = jsu_pkg::PHASE_STR;
                end
                else
                begin
                    hex_count_next = hex_count_reg + 2'd1;
                    code_point_next = cp_new;
                end
            end
            default:
            begin
                if (text.text_byte == jsu_pkg::CHAR_QUOTE)
                begin
                    phase_next = jsu_pkg::PHASE_STR;
                    hex_count_next = 2'd0;
                    code_point_next = 16'd0;
                end
                else
                begin
                    cmd.has_tail = 1'b1;
                    cmd.tail_kind = jsu_pkg::KIND_ERROR;
                    idle_err = 1'b1;
                end
            end
        endcase
        // text ran out inside the string
        if (text.end_of_text && !idle_err && phase_next != jsu_pkg::PHASE_IDLE)
        begin
            cmd.has_tail = 1'b1;
            cmd.tail_kind = jsu_pkg::KIND_ERROR;
            phase_next = jsu_pkg::PHASE_IDLE;
            hex_count_next = 2'd0;
            code_point_next = 16'd0;
        end
    end

    assign push = accept && (cmd.has_tail || cmd.ndata != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsu_pkg::PHASE_IDLE;
            hex_count_reg <= 2'd0;
            code_point_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hex_count_reg <= hex_count_next;
            code_point_reg <= code_point_next;
        end
    end

endmodule

// ----- hdl/jsu_queue.sv -----
module jsu_queue
#(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output jsu_pkg::cmd_t head_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- hdl/jsu_back.sv -----
module jsu_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  jsu_pkg::cmd_t    head_cmd,
    input  logic             result_stall,
    output logic             pop,
    output logic             result_valid,
    output jsu_pkg::result_t result
);

    logic [1:0]       pos_reg;
    logic [1:0]       pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    jsu_pkg::result_t out_reg;
    jsu_pkg::result_t res;
    logic [2:0]       total;
    logic             is_last;
    logic             open;
    logic             load;

    assign total = {1'b0, head_cmd.ndata} + {2'd0, head_cmd.has_tail};
    assign is_last = ({1'b0, pos_reg} == total - 3'd1);
    assign open = !out_valid_reg || !result_stall;
    assign load = head_valid && open;
    assign pop = load && is_last;

    always_comb
    begin
        res.last = is_last;
        if (pos_reg < head_cmd.ndata)
        begin
            res.kind = jsu_pkg::KIND_DATA;
            case (pos_reg)
                2'd0: res.data_byte = head_cmd.data[0];
                2'd1: res.data_byte = head_cmd.data[1];
                default: res.data_byte = head_cmd.data[2];
            endcase
        end
        else
        begin
            res.kind = head_cmd.tail_kind;
            res.data_byte = 8'd0;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        out_valid_next = out_valid_reg;
        if (open)
            out_valid_next = head_valid;
        if (load)
            pos_next = is_last ? 2'd0 : pos_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res;
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

`ifndef ASSERT_OFF
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> pos_reg == 2'd0)
        else $error("result index not at zero with empty queue");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> {1'b0, pos_reg} < total)
        else $error("result index beyond beat results");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> result_valid && result.last)
        else $error("queue entry popped without its last result");
`endif

endmodule

// ----- tb/json_string_unescape_utf8_tb.sv -----
module json_string_unescape_utf8_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 444;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    localparam jsu_pkg::result_t NOTHING_PINNED =
        '{data_byte: 8'h00, kind: jsu_pkg::KIND_DATA, last: 1'b0};
    localparam jsu_pkg::result_t ERROR_BEAT =
        '{data_byte: 8'h00, kind: jsu_pkg::KIND_ERROR, last: 1'b1};
    localparam jsu_pkg::result_t CLOSE_BEAT =
        '{data_byte: 8'h00, kind: jsu_pkg::KIND_CLOSE, last: 1'b1};

    typedef struct packed {
        logic [7:0]       text_byte;
        logic             end_of_text;
        logic             pinned;
        jsu_pkg::result_t pinned_result;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             text_valid = 1'b0;
    logic             text_stall;
    jsu_pkg::text_t   text = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    jsu_pkg::result_t result;

    jsu_pkg::phase_t  dec_phase = jsu_pkg::PHASE_IDLE;
    logic [1:0]       dec_hex_count = 2'd0;
    logic [15:0]      dec_code = 16'h0000;
    jsu_pkg::result_t step_results[$];
    jsu_pkg::result_t expected_results[$];

    logic [7:0]    simple_escapes [8];
    directed_row_t directed_rows [26];

    int   items_sent = 0;
    int   failures = 0;
    int   cycles = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;

    json_string_unescape_utf8 dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text         (text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [3:0] hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return 4'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return 4'(c - "a" + 10);
        end
        if (c >= "A" && c <= "F")
        begin
            return 4'(c - "A" + 10);
        end
        return 4'h0;
    endfunction

    function automatic void add_result(logic [7:0] b, jsu_pkg::kind_t k);
        jsu_pkg::result_t r;
        r.data_byte = b;
        r.kind = k;
        r.last = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void add_utf8(logic [15:0] cp);
        if (cp <= 16'h007f)
        begin
            add_result(cp[7:0], jsu_pkg::KIND_DATA);
        end
        else if (cp <= 16'h07ff)
        begin
            add_result(jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}, jsu_pkg::KIND_DATA);
            add_result(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::KIND_DATA);
        end
        else
        begin
            add_result(jsu_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]}, jsu_pkg::KIND_DATA);
            add_result(jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]}, jsu_pkg::KIND_DATA);
            add_result(jsu_pkg::UTF8_CONT | {2'b00, cp[5:0]}, jsu_pkg::KIND_DATA);
        end
    endfunction

    // advances the decoder state by one text byte, leaves its output in step_results
    function automatic void decode_text(logic [7:0] c, logic eot);
        step_results.delete();
        case (dec_phase)
            jsu_pkg::PHASE_STR:
            begin
                if (c == jsu_pkg::CHAR_QUOTE || c == jsu_pkg::CHAR_NUL)
                begin
                    add_result(8'h00, jsu_pkg::KIND_CLOSE);
                    dec_phase = jsu_pkg::PHASE_IDLE;
                end
                else if (c == jsu_pkg::CHAR_BACKSLASH)
                begin
                    dec_phase = jsu_pkg::PHASE_ESC;
                end
                else
                begin
                    add_result(c, jsu_pkg::KIND_DATA);
                end
            end
            jsu_pkg::PHASE_ESC:
            begin
                dec_phase = jsu_pkg::PHASE_STR;
                case (c)
                    jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH:
                        add_result(c, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_B: add_result(jsu_pkg::CTRL_BS, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_F: add_result(jsu_pkg::CTRL_FF, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_N: add_result(jsu_pkg::CTRL_LF, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_R: add_result(jsu_pkg::CTRL_CR, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_T: add_result(jsu_pkg::CTRL_TAB, jsu_pkg::KIND_DATA);
                    jsu_pkg::CHAR_U:
                    begin
                        dec_phase = jsu_pkg::PHASE_HEX;
                        dec_hex_count = 2'd0;
                        dec_code = 16'h0000;
                    end
                    default: ;
                endcase
            end
            jsu_pkg::PHASE_HEX:
            begin
                dec_code = {dec_code[11:0], hex_value(c)};
                if (dec_hex_count == 2'd3)
                begin
                    add_utf8(dec_code);
                    dec_hex_count = 2'd0;
                    dec_code = 16'h0000;
                    dec_phase = jsu_pkg::PHASE_STR;
                end
                else
                begin
                    dec_hex_count = dec_hex_count + 2'd1;
                end
            end
            default:
            begin
                if (c == jsu_pkg::CHAR_QUOTE)
                begin
                    dec_phase = jsu_pkg::PHASE_STR;
                    dec_hex_count = 2'd0;
                    dec_code = 16'h0000;
                end
                else
                begin
                    add_result(8'h00, jsu_pkg::KIND_ERROR);
                    return;
                end
            end
        endcase
        if (eot && dec_phase != jsu_pkg::PHASE_IDLE)
        begin
            add_result(8'h00, jsu_pkg::KIND_ERROR);
            dec_phase = jsu_pkg::PHASE_IDLE;
            dec_hex_count = 2'd0;
            dec_code = 16'h0000;
        end
    endfunction

    task automatic send_text(input logic [7:0] b, input logic eot, input logic pinned,
                             input jsu_pkg::result_t pin);
        jsu_pkg::result_t r;
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text <= '{text_byte: b, end_of_text: eot};
        do
            @(posedge clk);
        while (text_stall);
        decode_text(b, eot);
        if (pinned)
        begin
            expected_results.insert(expected_results.size(), pin);
        end
        else
        begin
            for (int i = 0; i < step_results.size(); i++)
            begin
                r = step_results[i];
                r.last = (i == step_results.size() - 1);
                expected_results.insert(expected_results.size(), r);
            end
        end
        items_sent++;
    endtask

    // one string token with random content, sometimes noise or a cut-off token
    task automatic send_string();
        logic [7:0] token[$];
        logic [7:0] b;
        int         pick;
        int         lead;
        int         cut;
        logic       eot;
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                send_text(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                          NOTHING_PINNED);
            end
            return;
        end
        token.insert(token.size(), jsu_pkg::CHAR_QUOTE);
        repeat ($urandom_range(0, 10))
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BACKSLASH);
                token.insert(token.size(), b);
            end
            else if (pick < 7)
            begin
                token.insert(token.size(), jsu_pkg::CHAR_BACKSLASH);
                token.insert(token.size(), simple_escapes[$urandom_range(0, 7)]);
            end
            else if (pick == 7)
            begin
                token.insert(token.size(), jsu_pkg::CHAR_BACKSLASH);
                token.insert(token.size(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                token.insert(token.size(), jsu_pkg::CHAR_BACKSLASH);
                token.insert(token.size(), jsu_pkg::CHAR_U);
                lead = $urandom_range(0, 2);
                for (int i = 0; i < 4; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    else if ((lead == 0 && i < 2) || (lead == 1 && i == 0))
                    begin
                        b = "0";
                    end
                    else if (lead == 1 && i == 1)
                    begin
                        b = HEX_CHARS[$urandom_range(0, 7)];
                    end
                    else
                    begin
                        b = HEX_CHARS[$urandom_range(0, 21)];
                    end
                    token.insert(token.size(), b);
                end
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 15)
        begin
            token.insert(token.size(), jsu_pkg::CHAR_QUOTE);
        end
        else if (pick < 17)
        begin
            token.insert(token.size(), jsu_pkg::CHAR_NUL);
        end
        cut = token.size() - 1;
        if (pick >= 17)
        begin
            cut = $urandom_range(0, token.size() - 1);
        end
        for (int i = 0; i <= cut; i++)
        begin
            eot = (i == cut) && (pick >= 17 || $urandom_range(0, 3) == 0);
            send_text(token[i], eot, 1'b0, NOTHING_PINNED);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= (receiver_stall_pct > 0) &&
                            ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        jsu_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: data_byte %02h kind %0d last %0b",
                       result.data_byte, result.kind, result.last);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.data_byte !== want.data_byte)
                begin
                    $error("data_byte expected %02h got %02h", want.data_byte, result.data_byte);
                    failures++;
                end
                if (result.kind !== want.kind)
                begin
                    $error("kind expected %0d got %0d", want.kind, result.kind);
                    failures++;
                end
                if (result.last !== want.last)
                begin
                    $error("last expected %0b got %0b", want.last, result.last);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        simple_escapes = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH,
                           jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_N,
                           jsu_pkg::CHAR_R, jsu_pkg::CHAR_T};
        directed_rows = '{
            '{"A",                     1'b0, 1'b1, ERROR_BEAT},
            '{jsu_pkg::CHAR_NUL,       1'b1, 1'b1, ERROR_BEAT},
            '{jsu_pkg::CHAR_QUOTE,     1'b0, 1'b0, NOTHING_PINNED},
            '{8'hff,                   1'b0, 1'b1, '{8'hff, jsu_pkg::KIND_DATA, 1'b1}},
            '{jsu_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_NUL,       1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_U,         1'b0, 1'b0, NOTHING_PINNED},
            '{"0",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"0",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"0",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"0",                     1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_U,         1'b0, 1'b0, NOTHING_PINNED},
            '{"g",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"7",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"F",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"f",                     1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_U,         1'b0, 1'b0, NOTHING_PINNED},
            '{"F",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"F",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"F",                     1'b0, 1'b0, NOTHING_PINNED},
            '{"f",                     1'b1, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_QUOTE,     1'b0, 1'b0, NOTHING_PINNED},
            '{jsu_pkg::CHAR_NUL,       1'b0, 1'b1, CLOSE_BEAT}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_text(directed_rows[i].text_byte, directed_rows[i].end_of_text,
                      directed_rows[i].pinned, directed_rows[i].pinned_result);
        end

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    // long receiver hold-off while beats keep coming
                    hold_req <= ~hold_req;
                end
                1:
                begin
                    sender_idle_pct = 66;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 66;
                end
                default:
                begin
                    sender_idle_pct = 25;
                    receiver_stall_pct = 25;
                end
            endcase
            while (items_sent < $size(directed_rows) + RANDOM_ITEMS * (p + 1) / 4)
            begin
                send_string();
            end
        end

        text_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_tb.sv
